FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for clocked checks that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: rtl/core/mrb_pkg.sv
// ----------------------------------------------------------------------------
// Modal resonator bank package
// Widths, word layout, command and configuration types shared by the block.
// ----------------------------------------------------------------------------
package mrb_pkg;

  localparam int MODE_W     = 6;
  localparam int NUM_MODES  = 2 ** MODE_W;
  localparam int DISP_WIDTH = 32;

  localparam int FB_W      = 24;
  localparam int DECAY_W   = 23;
  localparam int CF_W      = 32;
  localparam int MF_W      = 32;
  localparam int ACC_W     = 48;
  localparam int SCALE_W   = 32;
  localparam int SHIFT_W   = 6;
  localparam int COEF_FRAC = 22;

  // Input tdata layout, lowest field first
  localparam int TD_MODE_LSB  = 0;
  localparam int TD_FB_LSB    = TD_MODE_LSB + MODE_W;
  localparam int TD_DECAY_LSB = TD_FB_LSB + FB_W;
  localparam int TD_CF_LSB    = TD_DECAY_LSB + DECAY_W;
  localparam int TD_MF_LSB    = TD_CF_LSB + CF_W;
  localparam int TD_USED_W    = TD_MF_LSB + MF_W;
  localparam int TDATA_W      = ((TD_USED_W + 7) / 8) * 8;
  localparam int MDATA_W      = ((ACC_W + 7) / 8) * 8;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORCE_SHIFT = 2'd0,
    CFG_ACCEL_SCALE = 2'd1,
    CFG_ACCEL_SHIFT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [MODE_W-1:0]        mode;
    logic signed [FB_W-1:0]   coeff_feedback;
    logic [DECAY_W-1:0]       coeff_decay;
    logic signed [CF_W-1:0]   coeff_force;
    logic signed [MF_W-1:0]   modal_force;
    logic                     last_mode;
  } cmd_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] force_shift;
    logic [SCALE_W-1:0] accel_scale;
    logic [SHIFT_W-1:0] accel_shift;
  } cfg_t;

endpackage

FILE: rtl/core/mrb_front.sv
// ----------------------------------------------------------------------------
// Modal resonator bank front end
// Accepts input words, unpacks and classifies them and pushes a command.
// ----------------------------------------------------------------------------
module mrb_front (
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [mrb_pkg::TDATA_W-1:0]  s_axis_tdata,  // mode, coeff_feedback, coeff_decay,
                                                      // coeff_force, modal_force, zero pad
  input  logic                         s_axis_tuser,  // op
  input  logic                         s_axis_tlast,  // last_mode
  input  logic                         q_full_i,
  output logic                         push_o,
  output mrb_pkg::cmd_t                cmd_o
);
  import mrb_pkg::*;

  op_e op;

  assign op            = op_e'(s_axis_tuser);
  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  always_comb begin
    cmd_o.op             = op;
    cmd_o.mode           = s_axis_tdata[TD_MODE_LSB +: MODE_W];
    cmd_o.coeff_feedback = $signed(s_axis_tdata[TD_FB_LSB +: FB_W]);
    cmd_o.coeff_decay    = s_axis_tdata[TD_DECAY_LSB +: DECAY_W];
    cmd_o.coeff_force    = $signed(s_axis_tdata[TD_CF_LSB +: CF_W]);
    cmd_o.modal_force    = $signed(s_axis_tdata[TD_MF_LSB +: MF_W]);
    // a load never closes a tick
    cmd_o.last_mode      = (op == OP_SAMPLE) && s_axis_tlast;
  end

endmodule

FILE: rtl/core/mrb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Modal resonator bank command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrb_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mrb_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output mrb_pkg::cmd_t head_o
);
  import mrb_pkg::*;

  cmd_t              buf_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o       = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= cmd_i;
    end
  end

  `ASSERT_NEVER(a_fifo_ovf, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `ASSERT_NEVER(a_fifo_unf, clk_i, rst_ni, pop_i && !head_valid_o, "pop from empty queue")
  `ASSERT_CLK(a_fifo_cnt, clk_i, rst_ni, push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1, "count slip")

endmodule

FILE: rtl/core/mrb_back.sv
// ----------------------------------------------------------------------------
// Modal resonator bank back end
// Issues commands, updates mode history and coefficients, accumulates accel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrb_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mrb_pkg::cfg_t               cfg_i,
  input  logic                        head_valid_i,
  input  mrb_pkg::cmd_t               head_i,
  output logic                        pop_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [mrb_pkg::ACC_W-1:0]   accel_sum_o
);
  import mrb_pkg::*;

  localparam int T1_W  = FB_W + DISP_WIDTH;
  localparam int T2_W  = DECAY_W + 1 + DISP_WIDTH;
  localparam int T3_W  = CF_W + MF_W;
  localparam int SUM_W = T3_W + 1;
  localparam int D_W   = DISP_WIDTH + 3;
  localparam int AP_W  = D_W + SCALE_W + 1;

  typedef struct packed {
    logic signed [FB_W-1:0] coeff_feedback;
    logic [DECAY_W-1:0]     coeff_decay;
    logic signed [CF_W-1:0] coeff_force;
  } coef_t;

  typedef struct packed {
    logic signed [DISP_WIDTH-1:0] disp_prev;
    logic signed [DISP_WIDTH-1:0] disp_cur;
    logic signed [DISP_WIDTH-1:0] disp_next;
  } hist_t;

  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic                   last_mode;
    logic signed [MF_W-1:0] modal_force;
  } s1_t;

  typedef struct packed {
    logic [MODE_W-1:0]            mode;
    logic                         last_mode;
    logic signed [DISP_WIDTH-1:0] disp_cur;
    logic signed [DISP_WIDTH-1:0] disp_next;
    logic signed [T1_W-1:0]       t1;
    logic signed [T2_W-1:0]       t2;
    logic signed [T3_W-1:0]       t3;
    logic signed [D_W-1:0]        d;
  } s2_t;

  typedef struct packed {
    logic                   last_mode;
    logic signed [AP_W-1:0] prod;
  } s3_t;

  typedef struct packed {
    logic                    last_mode;
    logic signed [ACC_W-1:0] accel;
  } s4_t;

  function automatic logic signed [DISP_WIDTH-1:0] sat_disp(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-DISP_WIDTH:0] top;
    top = v[SUM_W-1:DISP_WIDTH-1];
    if ((&top) || !(|top)) sat_disp = v[DISP_WIDTH-1:0];
    else if (v[SUM_W-1])   sat_disp = {1'b1, {(DISP_WIDTH-1){1'b0}}};
    else                   sat_disp = {1'b0, {(DISP_WIDTH-1){1'b1}}};
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_prod(input logic signed [AP_W-1:0] v);
    logic [AP_W-ACC_W:0] top;
    top = v[AP_W-1:ACC_W-1];
    if ((&top) || !(|top)) sat_prod = v[ACC_W-1:0];
    else if (v[AP_W-1])    sat_prod = {1'b1, {(ACC_W-1){1'b0}}};
    else                   sat_prod = {1'b0, {(ACC_W-1){1'b1}}};
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    if (v[ACC_W] == v[ACC_W-1]) sat_acc = v[ACC_W-1:0];
    else if (v[ACC_W])          sat_acc = {1'b1, {(ACC_W-1){1'b0}}};
    else                        sat_acc = {1'b0, {(ACC_W-1){1'b1}}};
  endfunction

  // storage
  coef_t                coef_mem [NUM_MODES];
  hist_t                hist_mem [NUM_MODES];
  logic [NUM_MODES-1:0] hvld_q;

  coef_t coef_rd_q;
  hist_t hist_rd_q;
  logic  hvld_rd_q;

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  s1_t  s1_q;
  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;
  s4_t  s4_q, s4_d;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                    out_v_q;
  logic [ACC_W-1:0]        out_data_q;

  logic adv, hazard, issue, rd_en, ld_en;

  logic signed [DISP_WIDTH-1:0] h_prev, h_cur, h_next;
  logic signed [SUM_W-1:0]      s2_sum;
  logic signed [DISP_WIDTH-1:0] s2_new;
  logic signed [AP_W-1:0]       s3_shifted;
  logic signed [ACC_W:0]        acc_sum;

  // issue control
  assign adv    = !out_v_q || m_axis_tready;
  assign hazard = (head_i.op == OP_SAMPLE) &&
                  ((s1_v_q && (s1_q.mode == head_i.mode)) ||
                   (s2_v_q && (s2_q.mode == head_i.mode)));
  assign issue  = head_valid_i && adv && !hazard;
  assign rd_en  = issue && (head_i.op == OP_SAMPLE);
  assign ld_en  = issue && (head_i.op == OP_LOAD);
  assign pop_o  = issue;

  always_ff @(posedge clk_i) begin
    if (ld_en) begin
      coef_mem[head_i.mode] <= '{coeff_feedback: head_i.coeff_feedback,
                                 coeff_decay:    head_i.coeff_decay,
                                 coeff_force:    head_i.coeff_force};
    end
    if (rd_en) begin
      coef_rd_q <= coef_mem[head_i.mode];
      hist_rd_q <= hist_mem[head_i.mode];
      hvld_rd_q <= hvld_q[head_i.mode];
      s1_q      <= '{mode: head_i.mode, last_mode: head_i.last_mode,
                     modal_force: head_i.modal_force};
    end
    if (adv && s2_v_q) begin
      hist_mem[s2_q.mode] <= '{disp_prev: s2_q.disp_cur, disp_cur: s2_q.disp_next,
                               disp_next: s2_new};
    end
  end

  // products and second difference
  always_comb begin
    h_prev = hvld_rd_q ? hist_rd_q.disp_prev : '0;
    h_cur  = hvld_rd_q ? hist_rd_q.disp_cur  : '0;
    h_next = hvld_rd_q ? hist_rd_q.disp_next : '0;

    s2_d.mode      = s1_q.mode;
    s2_d.last_mode = s1_q.last_mode;
    s2_d.disp_cur  = h_cur;
    s2_d.disp_next = h_next;
    s2_d.t1 = T1_W'($signed(coef_rd_q.coeff_feedback)) * T1_W'(h_next);
    s2_d.t2 = T2_W'($signed({1'b0, coef_rd_q.coeff_decay})) * T2_W'(h_cur);
    s2_d.t3 = T3_W'($signed(coef_rd_q.coeff_force)) * T3_W'($signed(s1_q.modal_force));
    s2_d.d  = D_W'(h_next) + D_W'(h_prev) - (D_W'(h_cur) <<< 1);
  end

  // new displacement and acceleration product
  always_comb begin
    s2_sum = SUM_W'(s2_q.t1 >>> COEF_FRAC) - SUM_W'(s2_q.t2 >>> COEF_FRAC)
           + SUM_W'(s2_q.t3 >>> cfg_i.force_shift);
    s2_new = sat_disp(s2_sum);

    s3_d.last_mode = s2_q.last_mode;
    s3_d.prod      = AP_W'(s2_q.d) * AP_W'($signed({1'b0, cfg_i.accel_scale}));
  end

  // scaled acceleration and running sum
  always_comb begin
    s3_shifted     = s3_q.prod >>> cfg_i.accel_shift;
    s4_d.last_mode = s3_q.last_mode;
    s4_d.accel     = sat_prod(s3_shifted);

    acc_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(s4_q.accel);
    acc_d   = sat_acc(acc_sum);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      if (s4_v_q && s4_q.last_mode) begin
        out_data_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      acc_q   <= '0;
      out_v_q <= 1'b0;
      hvld_q  <= '0;
    end else if (adv) begin
      s1_v_q  <= rd_en;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      out_v_q <= s4_v_q && s4_q.last_mode;
      if (s4_v_q) begin
        acc_q <= s4_q.last_mode ? '0 : acc_d;
      end
      if (s2_v_q) begin
        hvld_q[s2_q.mode] <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign accel_sum_o   = out_data_q;

  `ASSERT_NEVER(a_mode_overlap, clk_i, rst_ni, s1_v_q && s2_v_q && (s1_q.mode == s2_q.mode), "same mode in flight twice")
  `ASSERT_CLK(a_acc_clear, clk_i, rst_ni, adv && s4_v_q && s4_q.last_mode |=> acc_q == '0, "sum not cleared after tick")
  `ASSERT_CLK(a_out_src, clk_i, rst_ni, out_v_q && !$past(out_v_q) |-> $past(s4_v_q && s4_q.last_mode), "result without closing sample")

endmodule

FILE: rtl/core/modal_resonator_bank_step.sv
// ----------------------------------------------------------------------------
// Modal resonator bank step
// Bank of damped two-pole modal resonators with a summed acceleration output.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per item. tuser = 0 loads one mode's feedback,
//   decay and force gain; tuser = 1 is a force sample for one mode, and
//   tlast marks the final sample of a tick. Only a closing sample yields a
//   word on m_axis: the saturated sum of the tick's modal accelerations.
//   cfg writes force_shift (0), accel_scale (1) and accel_shift (2); write
//   them only while the block is idle. cfg_ready_o is always high.
// Timing:
//   One item per cycle unless m_axis is held off or a sample waits at the
//   queue head. A closing sample passes the queue, stages s1 to s4 and the
//   output register before it shows on m_axis. A sample to a mode still in
//   the first two update stages waits for the history read-modify-write.
// Reset:
//   History, the running sum and the queue clear; registers return to
//   force_shift 0, accel_scale 1, accel_shift 0. Coefficients stay unknown
//   until loaded.
// Stall:
//   While m_axis is held off, the update pipeline freezes and the 4-word
//   queue fills; s_axis_tready drops once it is full.
// ----------------------------------------------------------------------------
module modal_resonator_bank_step (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mrb_pkg::TDATA_W-1:0]     s_axis_tdata,  // mode, coeff_feedback, coeff_decay,
                                                         // coeff_force, modal_force, zero pad
  input  logic                            s_axis_tuser,  // op
  input  logic                            s_axis_tlast,  // last_mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mrb_pkg::MDATA_W-1:0]     m_axis_tdata,  // accel_sum
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mrb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mrb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mrb_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd, head;
  logic push, pop, q_full, head_valid;
  logic [ACC_W-1:0] accel_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.force_shift <= '0;
      cfg_q.accel_scale <= SCALE_W'(1);
      cfg_q.accel_shift <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FORCE_SHIFT) cfg_q.force_shift <= cfg_data_i[SHIFT_W-1:0];
      if (cfg_index_i == CFG_ACCEL_SCALE) cfg_q.accel_scale <= cfg_data_i[SCALE_W-1:0];
      if (cfg_index_i == CFG_ACCEL_SHIFT) cfg_q.accel_shift <= cfg_data_i[SHIFT_W-1:0];
    end
  end

  mrb_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  mrb_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  mrb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .accel_sum_o   (accel_sum)
  );

  assign m_axis_tdata = MDATA_W'(accel_sum);

endmodule
